@@ src/qdbe_pkg.sv @@
// ----------------------------------------------------------------------------
// qdbe_pkg: shared types and constants
// Event codes, configuration register indexes and the quadrature step table
// for the detent and button event core.
// ----------------------------------------------------------------------------
package qdbe_pkg;

  typedef logic [2:0] event_code_t;

  // Event codes; the button codes follow on from EV_BTN_BASE in button order.
  localparam event_code_t EV_RIGHT    = 3'd0;
  localparam event_code_t EV_LEFT     = 3'd1;
  localparam event_code_t EV_BTN_BASE = 3'd2;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t CFG_ACTIVE_LEVEL     = 2'd0;
  localparam cfg_index_t CFG_STEPS_PER_DETENT = 2'd1;
  localparam cfg_index_t CFG_HOLDOFF_MS       = 2'd2;

  // Field widths.
  localparam int LEVELS_W  = 3;
  localparam int TIME_W    = 32;
  localparam int STEPS_W   = 4;
  localparam int HOLDOFF_W = 16;
  localparam int ACCUM_W   = 4;

  localparam logic [STEPS_W-1:0] STEPS_RESET   = 4'd4;
  localparam logic [STEPS_W-1:0] STEPS_MAX     = 4'd8;
  localparam logic [STEPS_W-1:0] STEPS_MIN     = 4'd1;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd40;

  // Quadrature step table, indexed by {previous A/B, current A/B}.
  localparam logic signed [1:0] QUAD_DELTA [0:15] = '{
    2'sb00, 2'sb11, 2'sb01, 2'sb00,
    2'sb01, 2'sb00, 2'sb00, 2'sb11,
    2'sb11, 2'sb00, 2'sb00, 2'sb01,
    2'sb00, 2'sb01, 2'sb11, 2'sb00
  };

endpackage

@@ src/qdbe_if.sv @@
// ----------------------------------------------------------------------------
// qdbe_if: sample and event channels
// Valid/ready channels for poll samples going in and events coming out.
// ----------------------------------------------------------------------------
interface qdbe_in_if;
  logic                          valid;
  logic                          ready;
  logic                          enc_a;
  logic                          enc_b;
  logic [qdbe_pkg::LEVELS_W-1:0] button_levels;
  logic [qdbe_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, enc_a, enc_b, button_levels, time_ms, input ready);
  modport sink   (input valid, enc_a, enc_b, button_levels, time_ms, output ready);
endinterface

interface qdbe_out_if;
  logic                  valid;
  logic                  ready;
  qdbe_pkg::event_code_t event_code;
  logic                  last_of_run;

  modport source (output valid, event_code, last_of_run, input ready);
  modport sink   (input valid, event_code, last_of_run, output ready);
endinterface

@@ src/quadrature_detent_and_button_events_core.sv @@
// ----------------------------------------------------------------------------
// quadrature_detent_and_button_events_core: encoder detent and button events
// Turns poll samples of a rotary encoder and its push buttons into a stream
// of RIGHT, LEFT and button-press event words.
// ----------------------------------------------------------------------------
// The core takes one poll sample word per clock while the result register is
// free, and answers with zero or more event words on the output channel,
// encoder event first, then buttons in index order, the final word of a sample
// marked by last_of_run. A sample goes into an input register; once the result
// register is free, short logic updates the encoder accumulator and the button
// state and drops the sample's events, as a bit mask, into the result register,
// which sends one event word per cycle while the output is ready. So the core
// keeps a rate of one sample per clock while the output is ready and each
// sample causes at most one event; a sample with more events holds the result
// register until its last word is taken, and a new sample moves in during the
// cycle that word leaves. The first sample after reset causes no encoder event,
// only loading the A/B reference pair; its buttons are still checked. The user
// must write configuration words only while the core is idle; the core does
// not enforce it. A steps_per_detent write also clears the step accumulator.
module quadrature_detent_and_button_events_core #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  qdbe_in_if.sink                in_ch,
  qdbe_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  qdbe_pkg::cfg_index_t   cfg_index,
  input  qdbe_pkg::cfg_data_t    cfg_wdata
);
  import qdbe_pkg::*;

  // One mask bit per possible event: right, left, then one per button.
  localparam int NUM_EV = 2 + NUM_BUTTONS;
  localparam int PAD_W  = LEVELS_W + NUM_BUTTONS;

  // Configuration registers.
  logic                 active_level_r;
  logic [STEPS_W-1:0]   steps_per_detent_r;
  logic [HOLDOFF_W-1:0] holdoff_ms_r;

  // Input register.
  logic                 a_valid_r;
  logic [1:0]           a_quad_r;
  logic [LEVELS_W-1:0]  a_levels_r;
  logic [TIME_W-1:0]    a_time_r;

  // Decoder state.
  logic [1:0]                 prev_quad_r;
  logic                       primed_r;
  logic signed [ACCUM_W-1:0]  step_accum_r;
  logic signed [ACCUM_W-1:0]  step_accum_nxt;
  logic [NUM_BUTTONS-1:0]     was_pressed_r;
  logic [NUM_BUTTONS-1:0]     pressed;
  logic [NUM_BUTTONS-1:0]     btn_fire;
  logic [TIME_W-1:0]          fire_time_r [NUM_BUTTONS];

  // Result register: pending events of the sample being delivered.
  logic [NUM_EV-1:0] ev_mask_r;
  logic [NUM_EV-1:0] ev_mask_nxt;
  logic [NUM_EV-1:0] new_mask;
  logic [NUM_EV-1:0] ev_lowest;
  logic [NUM_EV-1:0] ev_rest;

  // Handshake control.
  logic out_take;
  logic res_free;
  logic a_move;
  logic in_take;

  // Encoder datapath.
  logic [STEPS_W-1:0]        lim;
  logic signed [ACCUM_W:0]   lim_s;
  logic signed [1:0]         delta;
  logic signed [ACCUM_W:0]   sum;
  logic                      step_en;
  logic                      ev_right;
  logic                      ev_left;
  logic [PAD_W-1:0]          levels_pad;

  // --------------------------------------------------------------------------
  // Handshake. The result register frees up when it is empty or when its last
  // pending event is being taken; the input register moves on at that point.
  // --------------------------------------------------------------------------
  assign ev_lowest = ev_mask_r & (~ev_mask_r + NUM_EV'(1));
  assign ev_rest   = ev_mask_r & ~ev_lowest;

  assign out_take = out_ch.valid & out_ch.ready;
  assign res_free = (ev_mask_r == '0) | (out_take & (ev_rest == '0));
  assign a_move   = a_valid_r & res_free;
  assign in_ch.ready = ~a_valid_r | res_free;
  assign in_take  = in_ch.valid & in_ch.ready;

  assign out_ch.valid       = |ev_mask_r;
  assign out_ch.last_of_run = (ev_rest == '0);

  // The lowest pending bit gives the event code.
  always_comb begin
    out_ch.event_code = EV_RIGHT;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (ev_mask_r[i]) begin
        out_ch.event_code = event_code_t'(i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Encoder step. The detent size is clamped to 1..8, and the accumulator sum
  // is one bit wider so that it can reach plus or minus eight before pullback.
  // --------------------------------------------------------------------------
  always_comb begin
    if (steps_per_detent_r == '0) begin
      lim = STEPS_MIN;
    end else if (steps_per_detent_r > STEPS_MAX) begin
      lim = STEPS_MAX;
    end else begin
      lim = steps_per_detent_r;
    end
  end

  assign lim_s   = signed'({1'b0, lim});
  assign delta   = QUAD_DELTA[{prev_quad_r, a_quad_r}];
  assign step_en = primed_r & (delta != 2'sb00);
  assign sum     = signed'({step_accum_r[ACCUM_W-1], step_accum_r})
                 + signed'({{(ACCUM_W-1){delta[1]}}, delta});
  assign ev_right = step_en & (sum >= lim_s);
  assign ev_left  = step_en & (sum <= -lim_s);

  always_comb begin
    step_accum_nxt = step_accum_r;
    if (ev_right) begin
      step_accum_nxt = ACCUM_W'(sum - lim_s);
    end else if (ev_left) begin
      step_accum_nxt = ACCUM_W'(sum + lim_s);
    end else if (step_en) begin
      step_accum_nxt = ACCUM_W'(sum);
    end
  end

  // --------------------------------------------------------------------------
  // Buttons. A press fires when the button was released in the previous
  // sample and the holdoff has run out since it last fired; the elapsed time
  // is a wrapping 32-bit difference. Buttons beyond the three pins read low.
  // --------------------------------------------------------------------------
  assign levels_pad = PAD_W'(a_levels_r);

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      pressed[i]  = (levels_pad[i] == active_level_r);
      btn_fire[i] = pressed[i] & ~was_pressed_r[i]
                  & ((a_time_r - fire_time_r[i]) >= TIME_W'(holdoff_ms_r));
    end
  end

  always_comb begin
    new_mask = '0;
    new_mask[EV_RIGHT] = ev_right;
    new_mask[EV_LEFT]  = ev_left;
    new_mask[NUM_EV-1:EV_BTN_BASE] = btn_fire;
  end

  always_comb begin
    if (a_move) begin
      ev_mask_nxt = new_mask;
    end else if (out_take) begin
      ev_mask_nxt = ev_rest;
    end else begin
      ev_mask_nxt = ev_mask_r;
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r     <= 1'b0;
      steps_per_detent_r <= STEPS_RESET;
      holdoff_ms_r       <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LEVEL:     active_level_r     <= cfg_wdata[0];
        CFG_STEPS_PER_DETENT: steps_per_detent_r <= cfg_wdata[STEPS_W-1:0];
        CFG_HOLDOFF_MS:       holdoff_ms_r       <= cfg_wdata[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_quad_r   <= {in_ch.enc_a, in_ch.enc_b};
      a_levels_r <= in_ch.button_levels;
      a_time_r   <= in_ch.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_quad_r   <= 2'b00;
      primed_r      <= 1'b0;
      step_accum_r  <= '0;
      was_pressed_r <= '0;
      ev_mask_r     <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        fire_time_r[i] <= '0;
      end
    end else begin
      ev_mask_r <= ev_mask_nxt;
      if (cfg_we && (cfg_index == CFG_STEPS_PER_DETENT)) begin
        step_accum_r <= '0;
      end else if (a_move) begin
        step_accum_r <= step_accum_nxt;
      end
      if (a_move) begin
        prev_quad_r   <= a_quad_r;
        primed_r      <= 1'b1;
        was_pressed_r <= pressed;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (btn_fire[i]) begin
            fire_time_r[i] <= a_time_r;
          end
        end
      end
    end
  end

endmodule

@@ src/qdbe_checker.sv @@
// ----------------------------------------------------------------------------
// qdbe_checker: port-level checks for the detent and button event core
// Watches the event channel and the reset behavior of both channels.
// ----------------------------------------------------------------------------
module qdbe_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input qdbe_pkg::event_code_t event_code,
  input logic                  last_of_run
);
  import qdbe_pkg::*;

  // Out of reset the core is empty and ready for a sample.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("core not empty after reset");

  // A stalled event word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(event_code) && $stable(last_of_run)))
    else $error("event word changed while stalled");

  // A run of events continues without a gap until its last word.
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("gap inside an event run");

  // Within a run, events come out in rising code order.
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_of_run) |=> (event_code > $past(event_code)))
    else $error("event run out of order");

endmodule

bind quadrature_detent_and_button_events_core qdbe_checker u_qdbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_code  (out_ch.event_code),
  .last_of_run (out_ch.last_of_run)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for quadrature_detent_and_button_events_core
// Drives poll sample words through the input channel and checks every event
// word that comes out against a behavioral model kept in step with the core.
// The configuration registers change between phases, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  import qdbe_pkg::*;

  // The run stops here if the core hangs.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last expected word before config writes or the end.
  localparam int SETTLE_CYCLES = 8;
  // Number of mismatches that are printed in detail.
  localparam int REPORT_MAX = 10;
  // Index that no register answers to; a write there must change nothing.
  localparam cfg_index_t CFG_NO_REG = 2'd3;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 37;

  // One poll sample word as it travels on the input channel.
  typedef struct packed {
    logic                enc_a;
    logic                enc_b;
    logic [LEVELS_W-1:0] levels;
    logic [TIME_W-1:0]   time_ms;
  } sample_t;

  // One event word as it should appear on the output channel.
  typedef struct packed {
    event_code_t code;
    logic        last_flag;
  } event_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t cfg_wdata;

  qdbe_in_if  in_ch ();
  qdbe_out_if out_ch ();

  quadrature_detent_and_button_events_core #(
    .NUM_BUTTONS (3)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, and event words the core still owes us.
  sample_t     pending [$];
  event_word_t events_due [$];

  int  mismatches;
  int  cycles;
  bit  sending;
  bit  in_taken;
  int  gap_left;
  int  stall_left;
  bit  in_idle_on;
  bit  out_idle_on;
  sample_t drv_item;
  sample_t seen_item;

  // Model of the core: its configuration copy and its state.
  logic                   act_level_q;
  logic [STEPS_W-1:0]     steps_q;
  logic [HOLDOFF_W-1:0]   holdoff_q;
  logic [1:0]             prev_ab;
  logic                   primed;
  logic signed [ACCUM_W-1:0] accum;
  logic [2:0]             was_pressed;
  logic [TIME_W-1:0]      fire_time [3];

  // Stimulus generator state, so random sequences continue across items.
  logic [1:0]        gen_ab;
  bit                gen_up;
  logic [LEVELS_W-1:0] gen_levels;
  logic [TIME_W-1:0] gen_time;

  // Gap lengths: most are zero or short, a few are long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Direction of one A/B transition. A full cycle one way is 00,10,11,01 and
  // the other way 00,01,11,10; a jump over two bits or no change is no step.
  function automatic int quad_step(logic [1:0] from_ab, logic [1:0] to_ab);
    case ({from_ab, to_ab})
      4'b0010, 4'b1011, 4'b1101, 4'b0100: return 1;
      4'b0001, 4'b0111, 4'b1110, 4'b1000: return -1;
      default: return 0;
    endcase
  endfunction

  // The detent size is clamped into the legal range of 1 to 8.
  function automatic int detent_limit();
    if (steps_q < STEPS_MIN) return int'(STEPS_MIN);
    if (steps_q > STEPS_MAX) return int'(STEPS_MAX);
    return int'(steps_q);
  endfunction

  task automatic model_reset();
    act_level_q = 1'b0;
    steps_q     = STEPS_RESET;
    holdoff_q   = HOLDOFF_RESET;
    prev_ab     = 2'b00;
    primed      = 1'b0;
    accum       = '0;
    was_pressed = '0;
    for (int i = 0; i < 3; i++) fire_time[i] = '0;
  endtask

  task automatic model_config(cfg_index_t idx, cfg_data_t data);
    case (idx)
      CFG_ACTIVE_LEVEL: act_level_q = data[0];
      CFG_STEPS_PER_DETENT: begin
        steps_q = data[STEPS_W-1:0];
        // Changing the detent size also restarts the step count.
        accum = '0;
      end
      CFG_HOLDOFF_MS: holdoff_q = data[HOLDOFF_W-1:0];
      default: ;
    endcase
  endtask

  // Works out the event words that one accepted sample causes and queues them.
  task automatic decode_sample(sample_t s);
    logic [1:0]  ab;
    int          step;
    int          acc;
    int          lim;
    int          n;
    logic        pressed;
    event_word_t found [4];
    ab = {s.enc_a, s.enc_b};
    n = 0;
    if (!primed) begin
      // The first sample after reset only sets the reference pair.
      prev_ab = ab;
      primed = 1'b1;
    end else if (ab != prev_ab) begin
      step = quad_step(prev_ab, ab);
      prev_ab = ab;
      if (step != 0) begin
        acc = int'(accum) + step;
        lim = detent_limit();
        if (acc >= lim) begin
          acc -= lim;
          found[n] = '{code: EV_RIGHT, last_flag: 1'b0};
          n++;
        end else if (acc <= -lim) begin
          acc += lim;
          found[n] = '{code: EV_LEFT, last_flag: 1'b0};
          n++;
        end
        accum = acc[ACCUM_W-1:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      pressed = (s.levels[i] == act_level_q);
      // A press fires only on its leading edge and only once the holdoff has
      // run out; the time difference wraps like the 32-bit counter does.
      if (pressed && !was_pressed[i]) begin
        if (TIME_W'(s.time_ms - fire_time[i]) >= TIME_W'(holdoff_q)) begin
          fire_time[i] = s.time_ms;
          found[n] = '{code: event_code_t'(int'(EV_BTN_BASE) + i), last_flag: 1'b0};
          n++;
        end
      end
      was_pressed[i] = pressed;
    end
    if (n > 0) found[n-1].last_flag = 1'b1;
    for (int k = 0; k < n; k++) events_due.push_back(found[k]);
  endtask

  task automatic report_mismatch(string what, event_word_t want, event_word_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s: expected code %0d last %0b, got code %0d last %0b at cycle %0d",
               what, want.code, want.last_flag, got.code, got.last_flag, cycles);
    end
  endtask

  task automatic push_sample(logic a, logic b, logic [LEVELS_W-1:0] lv, logic [TIME_W-1:0] t);
    pending.push_back('{enc_a: a, enc_b: b, levels: lv, time_ms: t});
  endtask

  // Builds random samples. Most follow a real encoder turning one way with
  // occasional reversals, buttons going down and up, and time moving around
  // the holdoff; the rest are glitches, two-bit jumps and unrelated noise.
  task automatic queue_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_sample(1'($urandom), 1'($urandom), LEVELS_W'($urandom), $urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r >= 70 && r < 80) begin
          // Encoder at rest.
        end else if (r >= 94) begin
          gen_ab = 2'($urandom);
        end else if (r >= 88) begin
          gen_ab = gen_ab ^ 2'b11;
        end else begin
          if (r >= 80) gen_up = ~gen_up;
          // Walk the Gray sequence one step in the current direction.
          case (gen_ab)
            2'b00: gen_ab = gen_up ? 2'b10 : 2'b01;
            2'b10: gen_ab = gen_up ? 2'b11 : 2'b00;
            2'b11: gen_ab = gen_up ? 2'b01 : 2'b10;
            default: gen_ab = gen_up ? 2'b00 : 2'b11;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 25) gen_levels[$urandom_range(0, 2)] ^= 1'b1;
        else if (r < 30) gen_levels = LEVELS_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55) gen_time += $urandom_range(0, 3);
        else if (r < 85) gen_time += $urandom_range(0, holdoff_q * 2 + 2);
        else if (r < 95) gen_time += holdoff_q + $urandom_range(0, 2) - 1;
        else gen_time = $urandom;
        push_sample(gen_ab[1], gen_ab[0], gen_levels, gen_time);
      end
    end
  endtask

  // A configuration write takes effect at the rising edge inside the pulse.
  task automatic cfg_write(cfg_index_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_config(idx, data);
  endtask

  // Waits until every queued sample has gone in and every owed event word has
  // come out, then lets the pipeline drain samples that caused no events.
  task automatic wait_idle();
    while (pending.size() != 0 || sending || events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input side bookkeeping: a word is taken when valid and ready are both high
  // at the rising edge, and the model steps on exactly those words.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_item = '{enc_a: in_ch.enc_a, enc_b: in_ch.enc_b,
                    levels: in_ch.button_levels, time_ms: in_ch.time_ms};
      decode_sample(seen_item);
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: holds a word until it is taken, then either idles for a while or
  // presents the next one without dropping valid. Idle cycles carry junk.
  always @(negedge clk) begin
    if (rst_n) begin
      if (sending && in_taken) begin
        sending = 1'b0;
        gap_left = in_idle_on ? idle_gap() : 0;
      end
      if (!sending) begin
        if (gap_left == 0 && pending.size() != 0) begin
          drv_item = pending.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.enc_a         <= drv_item.enc_a;
          in_ch.enc_b         <= drv_item.enc_b;
          in_ch.button_levels <= drv_item.levels;
          in_ch.time_ms       <= drv_item.time_ms;
          sending = 1'b1;
        end else begin
          if (gap_left != 0) gap_left--;
          in_ch.valid         <= 1'b0;
          in_ch.enc_a         <= 1'($urandom);
          in_ch.enc_b         <= 1'($urandom);
          in_ch.button_levels <= LEVELS_W'($urandom);
          in_ch.time_ms       <= $urandom;
        end
      end
    end
  end

  // Receiver back-pressure: ready drops for random stretches.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_idle_on) stall_left = idle_gap();
      end
    end
  end

  // Monitor: every event word taken is checked against the oldest one owed.
  always @(posedge clk) begin : result_check
    event_word_t got;
    event_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{code: out_ch.event_code, last_flag: out_ch.last_of_run};
      if (events_due.size() == 0) begin
        report_mismatch("unexpected event word", '0, got);
      end else begin
        want = events_due.pop_front();
        if (got.code !== want.code || got.last_flag !== want.last_flag)
          report_mismatch("event word mismatch", want, got);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d event words still owed", cycles,
               events_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.enc_a = 1'b0;
    in_ch.enc_b = 1'b0;
    in_ch.button_levels = '0;
    in_ch.time_ms = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    sending = 1'b0;
    in_taken = 1'b0;
    gap_left = 0;
    stall_left = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    gen_ab = 2'b00;
    gen_up = 1'b1;
    gen_levels = '1;
    gen_time = '0;
    model_reset();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset configuration: active low buttons, four steps
    // per detent and a 40 ms holdoff. The first sample only sets the reference.
    push_sample(1'b1, 1'b1, 3'b111, 32'd0);
    // Four steps clockwise; the fourth makes a detent while all three buttons
    // go down together, so one sample causes the most words it can.
    push_sample(1'b0, 1'b1, 3'b111, 32'd1);
    push_sample(1'b0, 1'b0, 3'b111, 32'd2);
    push_sample(1'b1, 1'b0, 3'b111, 32'd3);
    push_sample(1'b1, 1'b1, 3'b000, 32'd100);
    // Pins unchanged and buttons held: nothing.
    push_sample(1'b1, 1'b1, 3'b000, 32'd101);
    // Both encoder bits flip at once, which is not a step.
    push_sample(1'b0, 1'b0, 3'b111, 32'd102);
    // Four steps the other way; menu comes back one ms short of the holdoff.
    push_sample(1'b0, 1'b1, 3'b111, 32'd103);
    push_sample(1'b1, 1'b1, 3'b111, 32'd104);
    push_sample(1'b1, 1'b0, 3'b111, 32'd105);
    push_sample(1'b0, 1'b0, 3'b110, 32'd139);
    push_sample(1'b0, 1'b0, 3'b111, 32'd140);
    // Exactly at the holdoff the press fires.
    push_sample(1'b0, 1'b0, 3'b110, 32'd140);
    // Back fires near the top of the time counter, then the counter wraps.
    push_sample(1'b0, 1'b0, 3'b101, 32'hFFFF_FFF0);
    push_sample(1'b0, 1'b0, 3'b111, 32'hFFFF_FFF8);
    push_sample(1'b0, 1'b0, 3'b101, 32'h0000_0010);
    push_sample(1'b0, 1'b0, 3'b111, 32'h0000_0017);
    push_sample(1'b0, 1'b0, 3'b101, 32'h0000_0018);
    push_sample(1'b0, 1'b1, 3'b011, 32'h7FFF_FFFF);
    push_sample(1'b0, 1'b0, 3'b111, 32'h8000_0000);
    push_sample(1'b0, 1'b0, 3'b000, 32'hFFFF_FFFF);
    gen_ab = 2'b00;
    gen_levels = 3'b000;
    gen_time = 32'hFFFF_FFFF;
    wait_idle();

    // Random phases, each under its own register settings. The first four
    // cover the extremes, including detent sizes outside the legal range and
    // a write to an index that holds no register.
    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      case (phase)
        1: begin
          cfg_write(CFG_ACTIVE_LEVEL, 16'h0001);
          cfg_write(CFG_STEPS_PER_DETENT, 16'd1);
          cfg_write(CFG_HOLDOFF_MS, 16'd0);
          in_idle_on = 1'b1;
          out_idle_on = 1'b1;
        end
        2: begin
          cfg_write(CFG_ACTIVE_LEVEL, {15'($urandom), 1'b0});
          cfg_write(CFG_STEPS_PER_DETENT, 16'd8);
          cfg_write(CFG_HOLDOFF_MS, 16'hFFFF);
          in_idle_on = 1'b0;
          out_idle_on = 1'b0;
        end
        3: begin
          cfg_write(CFG_ACTIVE_LEVEL, 16'h0001);
          cfg_write(CFG_STEPS_PER_DETENT, 16'd0);
          cfg_write(CFG_HOLDOFF_MS, 16'd1);
          cfg_write(CFG_NO_REG, 16'($urandom));
          in_idle_on = 1'b1;
          out_idle_on = 1'b0;
        end
        4: begin
          cfg_write(CFG_STEPS_PER_DETENT, {12'($urandom), 4'hF});
          cfg_write(CFG_HOLDOFF_MS, 16'd40);
          in_idle_on = 1'b0;
          out_idle_on = 1'b1;
        end
        default: begin
          cfg_write(CFG_ACTIVE_LEVEL, 16'($urandom));
          cfg_write(CFG_STEPS_PER_DETENT, 16'($urandom_range(0, 15)));
          cfg_write(CFG_HOLDOFF_MS, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 100)));
          in_idle_on = ($urandom_range(0, 3) != 0);
          out_idle_on = ($urandom_range(0, 3) != 0);
        end
      endcase
      queue_random(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/qdbe_pkg.sv
src/qdbe_if.sv
src/quadrature_detent_and_button_events_core.sv
src/qdbe_checker.sv
sim/tb.sv
